[rtl/mvfe_pkg.sv]
// Shared types and constants of the multichannel volume fade engine.
// Command codes, fade direction codes, step mapping and the control/status
// structs between controller and datapath. No dependencies.
package mvfe_pkg;

    typedef enum logic [1:0] {
        CMD_SET_VOL    = 2'd0,
        CMD_START_FADE = 2'd1,
        CMD_TICK       = 2'd2,
        CMD_STOP_ALL   = 2'd3
    } cmd_t;

    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [6:0] VOL_MAX      = 7'd127;
    localparam logic [2:0] STEP_DEFAULT = 3'd3;

    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 16;
    localparam int OUT_USER_W  = 5;

    // Controller -> datapath
    typedef struct packed {
        logic load;     // latch the accepted request
        logic exec;     // run the command's action
        logic walk;     // process the channel under the walk index
        logic summary;  // emit the closing result
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic walk_go;   // tick must walk the channels
        logic last_idx;  // walk index sits on the last channel
        logic out_free;  // output register can take a result this cycle
    } dp_stat_t;

    // Keep steps 1, 2, 4, 5; everything else becomes the default step.
    function automatic logic [2:0] map_step(input logic [7:0] code);
        logic [2:0] s;
        if (code == 8'd1 || code == 8'd2 || code == 8'd4 || code == 8'd5) begin
            s = code[2:0];
        end else begin
            s = STEP_DEFAULT;
        end
        return s;
    endfunction

endpackage

[rtl/mvfe_ctrl.sv]
// Controller of the volume fade engine: sequences accept, execute,
// channel walk and summary. Depends on mvfe_pkg.
module mvfe_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mvfe_pkg::dp_stat_t stat,
    output mvfe_pkg::dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_SUMM
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb begin
        cmd         = '0;
        cmd.load    = accept;
        cmd.exec    = (state_reg == ST_EXEC) && stat.out_free;
        cmd.walk    = (state_reg == ST_WALK) && stat.out_free;
        cmd.summary = (state_reg == ST_SUMM) && stat.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_EXEC;
                        ready_reg <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    if (stat.out_free) begin
                        if (stat.cmd == mvfe_pkg::CMD_TICK && stat.walk_go) begin
                            state_reg <= ST_WALK;
                        end else begin
                            state_reg <= ST_SUMM;
                        end
                    end
                end
                ST_WALK: begin
                    if (stat.out_free && stat.last_idx) begin
                        state_reg <= ST_SUMM;
                    end
                end
                ST_SUMM: begin
                    if (stat.out_free) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

[rtl/mvfe_dp.sv]
// Datapath of the volume fade engine: request latch, per-channel fade state,
// step arithmetic and the output register. Depends on mvfe_pkg.
module mvfe_dp #(
    parameter int CHANNELS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [mvfe_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                        s_tuser,
    input  logic                              cfg_we,
    input  logic                              cfg_data,
    input  mvfe_pkg::dp_cmd_t                 cmd,
    output mvfe_pkg::dp_stat_t                stat,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [mvfe_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [mvfe_pkg::OUT_USER_W-1:0]   m_tuser,
    output logic                              m_tlast
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [5:0] CH_LIMIT = 6'(CHANNELS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    // Latched request
    mvfe_pkg::cmd_t cmd_reg;
    logic [4:0]     ch_reg;
    logic [6:0]     lvl_reg;
    logic [2:0]     step_reg;
    logic           stop_reg;
    logic [31:0]    mask_reg;

    // Per-channel fade state
    logic [6:0] vol_reg   [CHANNELS];
    logic [6:0] tgt_reg   [CHANNELS];
    logic [1:0] dir_reg   [CHANNELS];
    logic [2:0] ssize_reg [CHANNELS];
    logic       stopf_reg [CHANNELS];

    logic             en_reg;
    logic             timer_off_reg;
    logic             fading_reg;
    logic             start_reg;
    logic             rel_reg;
    logic             active_reg;
    logic [IDX_W-1:0] idx_reg;

    // Output register
    logic       ov_reg;
    logic [4:0] o_ch_reg;
    logic [6:0] o_vol_reg;
    logic       o_apply_reg, o_end_reg, o_start_reg, o_rel_reg, o_act_reg, o_last_reg;

    logic             out_free;
    logic             ch_ok;
    logic [IDX_W-1:0] addr;
    logic [6:0]       rd_vol, rd_tgt;
    logic [1:0]       rd_dir;
    logic [2:0]       rd_step;
    logic             rd_stopf;
    logic             fad, playing, done;
    logic [7:0]       up_sum, dn_lim;
    logic [6:0]       nv;
    logic             walk_emit;
    logic [6:0]       in_lvl;
    logic             ov_load;

    assign out_free = !ov_reg || m_tready;
    assign ch_ok    = {1'b0, ch_reg} < CH_LIMIT;
    assign addr     = cmd.walk ? idx_reg : (ch_ok ? ch_reg[IDX_W-1:0] : '0);

    assign rd_vol   = vol_reg[addr];
    assign rd_tgt   = tgt_reg[addr];
    assign rd_dir   = dir_reg[addr];
    assign rd_step  = ssize_reg[addr];
    assign rd_stopf = stopf_reg[addr];

    assign fad     = (rd_dir == mvfe_pkg::DIR_UP) || (rd_dir == mvfe_pkg::DIR_DOWN);
    assign playing = mask_reg[idx_reg];
    assign done    = (rd_dir == mvfe_pkg::DIR_UP) ? (rd_tgt <= rd_vol) : (rd_tgt >= rd_vol);
    assign up_sum  = {1'b0, rd_vol} + {5'b0, rd_step};
    assign dn_lim  = {1'b0, rd_tgt} + {5'b0, rd_step};

    always_comb begin
        if (rd_dir == mvfe_pkg::DIR_UP) begin
            nv = (up_sum > {1'b0, rd_tgt}) ? rd_tgt : up_sum[6:0];
        end else begin
            nv = ({1'b0, rd_vol} > dn_lim) ? (rd_vol - {4'b0, rd_step}) : rd_tgt;
        end
    end

    assign walk_emit = fad && playing && (!done || rd_stopf);
    assign in_lvl    = (s_tdata[12:5] > {1'b0, mvfe_pkg::VOL_MAX}) ?
                       mvfe_pkg::VOL_MAX : s_tdata[11:5];

    // a new result enters the output register this cycle
    assign ov_load = cmd.summary || (cmd.walk && walk_emit) ||
                     (cmd.exec && cmd_reg == mvfe_pkg::CMD_SET_VOL && ch_ok);

    always_comb begin
        stat          = '0;
        stat.cmd      = cmd_reg;
        stat.walk_go  = en_reg && !timer_off_reg;
        stat.last_idx = (idx_reg == LAST_IDX);
        stat.out_free = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                vol_reg[i]   <= '0;
                tgt_reg[i]   <= '0;
                dir_reg[i]   <= mvfe_pkg::DIR_IDLE;
                ssize_reg[i] <= mvfe_pkg::STEP_DEFAULT;
                stopf_reg[i] <= 1'b0;
            end
            en_reg        <= 1'b1;
            timer_off_reg <= 1'b0;
            fading_reg    <= 1'b0;
            start_reg     <= 1'b0;
            rel_reg       <= 1'b0;
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            ov_reg        <= 1'b0;
            cmd_reg       <= mvfe_pkg::CMD_SET_VOL;
        end else begin
            if (cfg_we) begin
                en_reg <= cfg_data;
            end

            if (cmd.load) begin
                cmd_reg   <= mvfe_pkg::cmd_t'(s_tuser);
                ch_reg    <= s_tdata[4:0];
                lvl_reg   <= in_lvl;
                step_reg  <= mvfe_pkg::map_step(s_tdata[20:13]);
                stop_reg  <= s_tdata[21];
                mask_reg  <= s_tdata[53:22];
                start_reg <= 1'b0;
                rel_reg   <= 1'b0;
            end

            // hold a new result, else drop the shown one once taken
            if (ov_load) begin
                ov_reg <= 1'b1;
            end else if (ov_reg && m_tready) begin
                ov_reg <= 1'b0;
            end

            if (cmd.exec) begin
                idx_reg    <= '0;
                active_reg <= 1'b0;
                unique case (cmd_reg)
                    mvfe_pkg::CMD_SET_VOL: begin
                        if (ch_ok) begin
                            vol_reg[addr] <= lvl_reg;
                            o_ch_reg    <= ch_reg;
                            o_vol_reg   <= lvl_reg;
                            o_apply_reg <= 1'b1;
                            o_end_reg   <= 1'b0;
                            o_start_reg <= 1'b0;
                            o_rel_reg   <= 1'b0;
                            o_act_reg   <= 1'b0;
                            o_last_reg  <= 1'b0;
                        end
                    end
                    mvfe_pkg::CMD_START_FADE: begin
                        if (en_reg && ch_ok && lvl_reg != rd_vol) begin
                            tgt_reg[addr]   <= lvl_reg;
                            stopf_reg[addr] <= stop_reg;
                            dir_reg[addr]   <= (lvl_reg <= rd_vol) ?
                                               mvfe_pkg::DIR_DOWN : mvfe_pkg::DIR_UP;
                            ssize_reg[addr] <= step_reg;
                            if (!fading_reg) begin
                                timer_off_reg <= 1'b0;
                                fading_reg    <= 1'b1;
                                start_reg     <= 1'b1;
                            end
                        end
                    end
                    mvfe_pkg::CMD_TICK: begin
                        if (!en_reg) begin
                            timer_off_reg <= 1'b1;
                            fading_reg    <= 1'b0;
                            for (int i = 0; i < CHANNELS; i++) begin
                                dir_reg[i]   <= mvfe_pkg::DIR_IDLE;
                                stopf_reg[i] <= 1'b0;
                            end
                        end else if (timer_off_reg) begin
                            rel_reg <= 1'b1;
                        end
                    end
                    mvfe_pkg::CMD_STOP_ALL: begin
                        if (fading_reg) begin
                            timer_off_reg <= 1'b1;
                            rel_reg       <= 1'b1;
                            fading_reg    <= 1'b0;
                            for (int i = 0; i < CHANNELS; i++) begin
                                dir_reg[i]   <= mvfe_pkg::DIR_IDLE;
                                stopf_reg[i] <= 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (cmd.walk) begin
                idx_reg    <= idx_reg + 1'b1;
                active_reg <= active_reg || fad;
                if (fad) begin
                    if (!playing) begin
                        dir_reg[addr]   <= mvfe_pkg::DIR_IDLE;
                        stopf_reg[addr] <= 1'b0;
                    end else if (done) begin
                        dir_reg[addr]   <= mvfe_pkg::DIR_IDLE;
                        stopf_reg[addr] <= 1'b0;
                    end else begin
                        vol_reg[addr] <= nv;
                    end
                end
                if (walk_emit) begin
                    o_ch_reg    <= 5'(idx_reg);
                    o_vol_reg   <= done ? 7'd0 : nv;
                    o_apply_reg <= !done;
                    o_end_reg   <= done;
                    o_start_reg <= 1'b0;
                    o_rel_reg   <= 1'b0;
                    o_act_reg   <= 1'b0;
                    o_last_reg  <= 1'b0;
                end
                // no channel was fading at all: switch the tick source off
                if (idx_reg == LAST_IDX && !(active_reg || fad)) begin
                    timer_off_reg <= 1'b1;
                    fading_reg    <= 1'b0;
                end
            end

            if (cmd.summary) begin
                o_ch_reg    <= '0;
                o_vol_reg   <= '0;
                o_apply_reg <= 1'b0;
                o_end_reg   <= 1'b0;
                o_start_reg <= start_reg;
                o_rel_reg   <= rel_reg;
                o_act_reg   <= fading_reg;
                o_last_reg  <= 1'b1;
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0, o_vol_reg, o_ch_reg};
    assign m_tuser  = {o_act_reg, o_rel_reg, o_start_reg, o_end_reg, o_apply_reg};
    assign m_tlast  = o_last_reg;

endmodule

[rtl/multichannel_volume_fade_engine.sv]
// Top level of the multichannel volume fade engine.
// Instantiates mvfe_ctrl and mvfe_dp; depends on mvfe_pkg.
//
// Usage: each request on the s_ stream carries one command (tuser): set a
// channel's volume, start a fade, tick the fades, or stop all fades. Results
// leave on the m_ stream; every request ends with one summary result marked
// with m_tlast. A set volume gives one channel result before the summary, a
// tick one result per channel whose volume moves or whose sample must end.
// The single sound_enabled register is written on the cfg_ channel, which is
// always ready; write it only while the engine is idle.
// Sequence: a request is taken in ST_IDLE, executed in ST_EXEC and closed
// by the summary in ST_SUMM; set volume, start fade, stop all and a tick
// that does not walk pass straight from ST_EXEC to ST_SUMM. A walking tick
// visits the channels in ST_WALK one per cycle through the shared step
// unit while the receiver does not stall. s_tready drops after each
// request and rises once the summary is in the output register, so the
// next request is taken while the summary still waits. A stalled receiver
// holds the output register and freezes the walk. Reset clears all fade
// state, volumes to zero, steps to three, sound_enabled to one.
module multichannel_volume_fade_engine #(
    parameter int CHANNELS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] channel, [12:5] level, [20:13] step_code, [21] stop_at_end,
    // [53:22] playing_mask, [55:54] zero
    input  logic [55:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] out_channel, [11:5] out_volume, [15:12] zero
    output logic [15:0] m_tdata,
    // [0] apply_volume, [1] end_sample, [2] start_timer, [3] release_timer,
    // [4] fading_active
    output logic [4:0]  m_tuser,
    output logic        m_tlast,
    // configuration write: sound_enabled
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    mvfe_pkg::dp_cmd_t  dp_cmd;
    mvfe_pkg::dp_stat_t dp_stat;

    // register write never waits
    assign cfg_ready = 1'b1;

    mvfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    mvfe_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // one request at a time: ready drops right after an accept
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one still in flight");

    // summary carries no channel action
    a_summary_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (!m_tuser[0] && !m_tuser[1]))
        else $error("summary result carries a channel action");

    // channel results carry no timer or activity flags
    a_channel_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (!m_tuser[2] && !m_tuser[3] && !m_tuser[4]))
        else $error("channel result carries summary flags");

    // timer start and release never come together
    a_timer_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[2] && m_tuser[3]))
        else $error("start and release of the tick source in one result");
`endif

endmodule
